FILE: design/rti_pkg.sv
package rti_pkg;

  localparam int NUM_AXES   = 6;
  localparam int MAX_POINTS = 16;

  localparam int AXIS_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int PTS_W   = 5;
  localparam int DATA_W  = 16;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 3;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  localparam int TBL_DEPTH = NUM_AXES * MAX_POINTS;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int AX_IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int DIV_CNT_W = $clog2(DATA_W);
  localparam int PROD_W    = 2 * (DATA_W + 1);

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [ST_W-1:0] ST_INTERP  = 3'd0;
  localparam logic [ST_W-1:0] ST_LOW     = 3'd1;
  localparam logic [ST_W-1:0] ST_HIGH    = 3'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd3;
  localparam logic [ST_W-1:0] ST_WRITTEN = 3'd4;

  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_RD   = 2'd1;
  localparam logic [1:0] RES_LO   = 2'd2;
  localparam logic [1:0] RES_HI   = 2'd3;

  typedef struct packed {
    logic             load_in;
    logic             mem_wr;
    logic             cnt_wr;
    logic [IDX_W-1:0] rd_idx;
    logic             res_load;
    logic [1:0]       res_sel;
    logic [ST_W-1:0]  res_st;
    logic             lo_load;
    logic             hi_load;
    logic             div_init;
    logic             div_step;
    logic             mul_amp;
    logic             mul_ph;
    logic             add_amp;
    logic             add_ph;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             axis_ok;
    logic             slot_ok;
    logic             cnt_zero;
    logic [CNT_W-1:0] n;
    logic             q_le_rd;
    logic             q_ge_rd;
    logic             flat;
    logic             num_ge;
    logic             out_free;
  } dp_stat_t;

endpackage

FILE: design/rao_table_interpolation.sv
// Piecewise-linear lookup over per-axis breakpoint tables.
// in_* : one beat per command. tuser carries the command (write breakpoint,
//   set point count, query); tdata carries axis, slot, points, freq, amp, phase.
// out_*: exactly one beat per input beat, in order. tdata = amplitude, phase;
//   tuser = status.
// One command is worked on at a time; in_tready is high only while idle.
// Writes, counts, invalid commands and empty tables go straight to the output
//   register; a low or a high clamp returns the first or the last table point;
//   a query that brackets between two points returns a table point when the
//   neighbors are equal or the hit is exact, and otherwise interpolates (table
//   reads through the single registered read port, one point at a time, then a
//   restoring divider and one shared multiplier for amplitude and phase).
// Commands are spaced by their latency: the next one is taken in the idle cycle
//   after the result is loaded into the output register.
// Reset clears all point counts to zero; breakpoint tables are not cleared and
//   must be written before they are queried.
// The result sits in an output register; while out_tready is low the block
//   still accepts one new command and holds its result until that beat leaves.
module rao_table_interpolation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // axis[2:0] slot[6:3] points[11:7] freq[27:12] amp_in[43:28] phase_in[59:44]
  input  logic [rti_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [rti_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // amp_out[15:0] phase_out[31:16]
  output logic [rti_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [rti_pkg::ST_W-1:0]        out_tuser
);

  rti_pkg::ctrl_cmd_t cmd;
  rti_pkg::dp_stat_t  stat;

  rti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rti_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == rti_pkg::ST_INVALID || out_tuser == rti_pkg::ST_WRITTEN)
      |-> out_tdata == '0)
    else $error("nonzero data on invalid or write result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while a command is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_tvalid || out_tready)
    else $error("result loaded over a pending output beat");

  a_single_table_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_wr && cmd.cnt_wr) && !(cmd.mem_wr && cmd.load_in))
    else $error("conflicting table updates");

endmodule

FILE: design/rti_dp.sv
module rti_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rti_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [rti_pkg::CMD_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rti_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [rti_pkg::ST_W-1:0]           out_tuser,
  input  rti_pkg::ctrl_cmd_t                 cmd,
  output rti_pkg::dp_stat_t                  stat
);

  localparam int DW = rti_pkg::DATA_W;

  logic [rti_pkg::CMD_W-1:0]  cmd_r;
  logic [rti_pkg::AXIS_W-1:0] axis_r;
  logic [rti_pkg::SLOT_W-1:0] slot_r;
  logic [rti_pkg::PTS_W-1:0]  pts_r;
  logic [DW-1:0]              q_r;
  logic [DW-1:0]              amp_in_r;
  logic [DW-1:0]              ph_in_r;

  logic [DW-1:0] freq_mem [rti_pkg::TBL_DEPTH];
  logic [DW-1:0] amp_mem  [rti_pkg::TBL_DEPTH];
  logic [DW-1:0] ph_mem   [rti_pkg::TBL_DEPTH];
  logic [DW-1:0] rd_f_r, rd_a_r, rd_p_r;

  logic [rti_pkg::CNT_W-1:0] cnt_r [rti_pkg::NUM_AXES];

  logic [DW-1:0] lo_f_r, lo_a_r, lo_p_r;
  logic [DW-1:0] hi_f_r, hi_a_r, hi_p_r;
  logic [DW-1:0] rem_r, quo_r;
  logic signed [rti_pkg::PROD_W-1:0] prod_r;

  logic [DW-1:0]             res_amp_r, res_ph_r;
  logic [rti_pkg::ST_W-1:0]  res_st_r;
  logic                      out_tvalid_r;
  logic [DW-1:0]             out_amp_r, out_ph_r;
  logic [rti_pkg::ST_W-1:0]  out_st_r;

  logic                         axis_ok;
  logic [rti_pkg::AX_IDX_W-1:0] axis_idx;
  logic [rti_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
  logic [rti_pkg::CNT_W-1:0]    n, cnt_sat;
  logic [DW-1:0]                num, dlt;
  logic [DW:0]                  r2;
  logic                         q_bit;
  logic signed [DW:0]           diff_a, diff_p, mul_op, t_s;

  assign axis_ok  = int'(axis_r) < rti_pkg::NUM_AXES;
  assign axis_idx = rti_pkg::AX_IDX_W'(axis_r);
  assign wr_addr  = rti_pkg::ADDR_W'(int'(axis_r) * rti_pkg::MAX_POINTS + int'(slot_r));
  assign rd_addr  = rti_pkg::ADDR_W'(int'(axis_r) * rti_pkg::MAX_POINTS + int'(cmd.rd_idx));
  assign n        = axis_ok ? cnt_r[axis_idx] : '0;
  assign cnt_sat  = (int'(pts_r) > rti_pkg::MAX_POINTS) ? rti_pkg::CNT_W'(rti_pkg::MAX_POINTS)
                                                        : rti_pkg::CNT_W'(pts_r);

  assign num    = (q_r > lo_f_r) ? q_r - lo_f_r : '0;
  assign dlt    = hi_f_r - lo_f_r;
  assign r2     = {rem_r, 1'b0};
  assign q_bit  = r2 >= {1'b0, dlt};
  assign diff_a = $signed({hi_a_r[DW-1], hi_a_r}) - $signed({lo_a_r[DW-1], lo_a_r});
  assign diff_p = $signed({hi_p_r[DW-1], hi_p_r}) - $signed({lo_p_r[DW-1], lo_p_r});
  assign mul_op = cmd.mul_ph ? diff_p : diff_a;
  assign t_s    = $signed({1'b0, quo_r});

  always_comb begin
    stat.cmd      = cmd_r;
    stat.axis_ok  = axis_ok;
    stat.slot_ok  = int'(slot_r) < rti_pkg::MAX_POINTS;
    stat.cnt_zero = n == '0;
    stat.n        = n;
    stat.q_le_rd  = q_r <= rd_f_r;
    stat.q_ge_rd  = q_r >= rd_f_r;
    stat.flat     = hi_f_r <= lo_f_r;
    stat.num_ge   = num >= dlt;
    stat.out_free = !out_tvalid_r || out_tready;
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r    <= in_tuser;
      axis_r   <= in_tdata[2:0];
      slot_r   <= in_tdata[6:3];
      pts_r    <= in_tdata[11:7];
      q_r      <= in_tdata[27:12];
      amp_in_r <= in_tdata[43:28];
      ph_in_r  <= in_tdata[59:44];
    end
  end

  // breakpoint tables
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      freq_mem[wr_addr] <= q_r;
      amp_mem[wr_addr]  <= amp_in_r;
      ph_mem[wr_addr]   <= ph_in_r;
    end
    if (axis_ok) begin
      rd_f_r <= freq_mem[rd_addr];
      rd_a_r <= amp_mem[rd_addr];
      rd_p_r <= ph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rti_pkg::NUM_AXES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.cnt_wr) begin
      cnt_r[axis_idx] <= cnt_sat;
    end
  end

  // bracketing points, divider, interpolation
  always_ff @(posedge clk) begin
    if (cmd.lo_load) begin
      lo_f_r <= rd_f_r;
      lo_a_r <= rd_a_r;
      lo_p_r <= rd_p_r;
    end
    if (cmd.hi_load) begin
      hi_f_r <= rd_f_r;
      hi_a_r <= rd_a_r;
      hi_p_r <= rd_p_r;
    end
    if (cmd.div_init) begin
      rem_r <= num;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? DW'(r2 - {1'b0, dlt}) : r2[DW-1:0];
      quo_r <= {quo_r[DW-2:0], q_bit};
    end
    if (cmd.mul_amp || cmd.mul_ph) begin
      prod_r <= mul_op * t_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st_r <= cmd.res_st;
      case (cmd.res_sel)
        rti_pkg::RES_RD: begin
          res_amp_r <= rd_a_r;
          res_ph_r  <= rd_p_r;
        end
        rti_pkg::RES_LO: begin
          res_amp_r <= lo_a_r;
          res_ph_r  <= lo_p_r;
        end
        rti_pkg::RES_HI: begin
          res_amp_r <= hi_a_r;
          res_ph_r  <= hi_p_r;
        end
        default: begin
          res_amp_r <= '0;
          res_ph_r  <= '0;
        end
      endcase
    end else begin
      if (cmd.add_amp) begin
        res_amp_r <= lo_a_r + prod_r[2*DW-1:DW];
      end
      if (cmd.add_ph) begin
        res_ph_r <= lo_p_r + prod_r[2*DW-1:DW];
        res_st_r <= cmd.res_st;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_amp_r <= res_amp_r;
      out_ph_r  <= res_ph_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_ph_r, out_amp_r};
  assign out_tuser  = out_st_r;

endmodule

FILE: design/rti_ctrl.sv
module rti_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rti_pkg::dp_stat_t  stat,
  output rti_pkg::ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LO   = 4'd2;
  localparam logic [3:0] S_HI   = 4'd3;
  localparam logic [3:0] S_SW   = 4'd4;
  localparam logic [3:0] S_SCK  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_MA   = 4'd8;
  localparam logic [3:0] S_MP   = 4'd9;
  localparam logic [3:0] S_AP   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [rti_pkg::DIV_CNT_W-1:0] DIV_LAST = rti_pkg::DIV_CNT_W'(rti_pkg::DATA_W - 1);

  logic [3:0]                      state_r, state_nxt;
  logic [rti_pkg::IDX_W-1:0]       k_r, k_nxt;
  logic [rti_pkg::DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                            k_last;

  assign in_tready = state_r == S_IDLE;
  assign k_last    = rti_pkg::CNT_W'(k_r) == (stat.n - rti_pkg::CNT_W'(1));

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.rd_idx  = k_r;
    cmd.res_sel = rti_pkg::RES_ZERO;
    cmd.res_st  = rti_pkg::ST_INVALID;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          k_nxt       = '0;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_OUT;
        unique case (stat.cmd)
          rti_pkg::CMD_WRITE: begin
            if (stat.axis_ok && stat.slot_ok) begin
              cmd.mem_wr = 1'b1;
              cmd.res_st = rti_pkg::ST_WRITTEN;
            end
          end
          rti_pkg::CMD_COUNT: begin
            if (stat.axis_ok) begin
              cmd.cnt_wr = 1'b1;
              cmd.res_st = rti_pkg::ST_WRITTEN;
            end
          end
          rti_pkg::CMD_QUERY: begin
            if (stat.axis_ok && !stat.cnt_zero) begin
              cmd.res_load = 1'b0;
              k_nxt        = rti_pkg::IDX_W'(stat.n - rti_pkg::CNT_W'(1));
              state_nxt    = S_LO;
            end
          end
          default: ;
        endcase
      end
      S_LO: begin
        if (stat.q_le_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rti_pkg::RES_RD;
          cmd.res_st   = rti_pkg::ST_LOW;
          state_nxt    = S_OUT;
        end else begin
          cmd.lo_load = 1'b1;
          state_nxt   = S_HI;
        end
      end
      S_HI: begin
        if (stat.q_ge_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rti_pkg::RES_RD;
          cmd.res_st   = rti_pkg::ST_HIGH;
          state_nxt    = S_OUT;
        end else begin
          k_nxt     = rti_pkg::IDX_W'(1);
          state_nxt = S_SW;
        end
      end
      S_SW: begin
        state_nxt = S_SCK;
      end
      S_SCK: begin
        // last point always brackets: the high clamp ruled out q >= f[n-1]
        if (stat.q_le_rd || k_last) begin
          cmd.hi_load = 1'b1;
          state_nxt   = S_CMP;
        end else begin
          cmd.lo_load = 1'b1;
          k_nxt       = k_r + rti_pkg::IDX_W'(1);
          state_nxt   = S_SW;
        end
      end
      S_CMP: begin
        if (stat.flat) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rti_pkg::RES_LO;
          cmd.res_st   = rti_pkg::ST_INTERP;
          state_nxt    = S_OUT;
        end else if (stat.num_ge) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rti_pkg::RES_HI;
          cmd.res_st   = rti_pkg::ST_INTERP;
          state_nxt    = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + rti_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_MA;
        end
      end
      S_MA: begin
        cmd.mul_amp = 1'b1;
        state_nxt   = S_MP;
      end
      S_MP: begin
        cmd.add_amp = 1'b1;
        cmd.mul_ph  = 1'b1;
        state_nxt   = S_AP;
      end
      S_AP: begin
        cmd.add_ph = 1'b1;
        cmd.res_st = rti_pkg::ST_INTERP;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule
